/* design/irpd_pkg.sv */
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types, register indexes, reset values and the key table of the
// pulse-distance IR decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

   localparam int FRAME_BITS_DEF = 32;
   localparam int NUM_KEYS_DEF   = 6;
   localparam int TIMER_BITS_DEF = 32;

   localparam int KEY_TABLE_SIZE = 21;
   localparam int CODE_BITS      = 32;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 16;

   typedef logic [CSR_ADDR_BITS-1:0] csr_addr_type;

   localparam csr_addr_type REG_START_INTERVAL = csr_addr_type'(0);
   localparam csr_addr_type REG_ONE_INTERVAL   = csr_addr_type'(1);
   localparam csr_addr_type REG_ZERO_INTERVAL  = csr_addr_type'(2);
   localparam csr_addr_type REG_TOLERANCE      = csr_addr_type'(3);

   localparam logic [CSR_DATA_BITS-1:0] START_INTERVAL_RST = 16'd6800;
   localparam logic [CSR_DATA_BITS-1:0] ONE_INTERVAL_RST   = 16'd1690;
   localparam logic [CSR_DATA_BITS-1:0] ZERO_INTERVAL_RST  = 16'd850;
   localparam logic [CSR_DATA_BITS-1:0] TOLERANCE_RST      = 16'd100;

   typedef enum logic [1:0] {
      STATUS_MATCH   = 2'd0,
      STATUS_BAD     = 2'd1,
      STATUS_NOMATCH = 2'd2
   } status_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] start_interval;
      logic [CSR_DATA_BITS-1:0] one_interval;
      logic [CSR_DATA_BITS-1:0] zero_interval;
      logic [CSR_DATA_BITS-1:0] tolerance;
   } cfg_type;

   typedef struct packed {
      logic start_gap;
      logic bit_one;
      logic bit_zero;
   } class_type;

   localparam logic [CODE_BITS-1:0] KEY_CODES [KEY_TABLE_SIZE] = '{
      32'd3772811383, 32'd3772784863, 32'd3772817503, 32'd3772801183,
      32'd3772780783, 32'd3772813423, 32'd3772797103, 32'd3772788943,
      32'd3772821583, 32'd3772805263, 32'd3772793023, 32'd3772778233,
      32'd3772810873, 32'd3772819033, 32'd3772794553, 32'd3772782313,
      32'd3772833823, 32'd3772829743, 32'd3772795063, 32'd3772778743,
      32'd3772837903
   };

endpackage

/* design/ir_pulse_distance_decoder_unit.sv */
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder_unit
// Pulse-distance IR remote decoder: one falling-edge timestamp per transfer,
// one code word with key index and status per completed frame.
// ----------------------------------------------------------------------------
// Pipeline: input register, then classify, shift and key compare into the
//   result register.
// Throughput: one edge per cycle while the result is not held back by rsp_tready.
// Reset: synchronous; frame state cleared, registers back to their defaults,
//   previous edge time taken as zero.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder_unit
   import irpd_pkg::*;
#(
   parameter int FRAME_BITS = FRAME_BITS_DEF,
   parameter int NUM_KEYS   = NUM_KEYS_DEF,
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // edge_time[31:0]
   input  logic [31:0]              req_tdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // code_word[31:0], key_index[34:32], zero fill[39:35]
   output logic [39:0]              rsp_tdata,
   // status[1:0]
   output logic [1:0]               rsp_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                     csr_valid,
   output logic                     csr_ready
);

   localparam int CNT_BITS = $clog2(FRAME_BITS + 1);

   cfg_type                 cfg_ff, cfg_in;
   logic                    s1_vld_ff, s1_vld_in;
   logic [31:0]             s1_time_ff;
   logic [TIMER_BITS-1:0]   last_ff, last_in;
   logic                    active_ff, active_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [CODE_BITS-1:0]    shift_ff, shift_in;
   logic                    bad_ff, bad_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic [CODE_BITS-1:0]    code_ff, code_in;
   logic [2:0]              key_ff, key_in;
   status_type              status_ff, status_in;

   logic [TIMER_BITS-1:0]   now_time;
   class_type               cls;
   logic                    req_fire;
   logic                    s1_fire;
   logic                    frame_done;
   logic [CODE_BITS-1:0]    shift_nxt;
   logic [CNT_BITS-1:0]     cnt_nxt;
   logic                    bad_nxt;
   logic                    key_hit;
   logic [2:0]              key_idx;

   assign csr_ready  = 1'b1;
   assign now_time   = TIMER_BITS'(s1_time_ff);
   assign s1_fire    = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   irpd_classify #(
      .TIMER_BITS(TIMER_BITS)
   ) u_classify (
      .now_time (now_time),
      .last_time(last_ff),
      .cfg      (cfg_ff),
      .cls      (cls)
   );

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            REG_START_INTERVAL: cfg_in.start_interval = csr_wdata;
            REG_ONE_INTERVAL:   cfg_in.one_interval   = csr_wdata;
            REG_ZERO_INTERVAL:  cfg_in.zero_interval  = csr_wdata;
            REG_TOLERANCE:      cfg_in.tolerance      = csr_wdata;
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   // data bit and key lookup on the code as it stands after this interval
   always_comb begin
      shift_nxt  = {shift_ff[CODE_BITS-2:0], cls.bit_one};
      cnt_nxt    = cnt_ff + 1'b1;
      bad_nxt    = bad_ff || (!cls.bit_one && !cls.bit_zero);
      frame_done = active_ff && !cls.start_gap && (cnt_nxt == CNT_BITS'(FRAME_BITS));
      key_hit    = 1'b0;
      key_idx    = 3'd0;
      // lowest matching index wins
      for (int k = NUM_KEYS - 1; k >= 0; k--) begin
         if (k < KEY_TABLE_SIZE) begin
            if (shift_nxt == KEY_CODES[k]) begin
               key_hit = 1'b1;
               key_idx = 3'(k);
            end
         end
      end
   end

   always_comb begin
      s1_vld_in = s1_vld_ff;
      last_in   = last_ff;
      active_in = active_ff;
      cnt_in    = cnt_ff;
      shift_in  = shift_ff;
      bad_in    = bad_ff;
      code_in   = code_ff;
      key_in    = key_ff;
      status_in = status_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_tready;

      if (req_fire) begin
         s1_vld_in = 1'b1;
      end else if (s1_fire) begin
         s1_vld_in = 1'b0;
      end

      if (s1_fire) begin
         last_in = now_time;
         if (cls.start_gap) begin
            // restart the frame, drop collected bits
            active_in = 1'b1;
            cnt_in    = '0;
            shift_in  = '0;
            bad_in    = 1'b0;
         end else if (frame_done) begin
            active_in  = 1'b0;
            cnt_in     = '0;
            shift_in   = '0;
            bad_in     = 1'b0;
            rsp_vld_in = 1'b1;
            if (bad_nxt) begin
               code_in   = '0;
               key_in    = 3'd0;
               status_in = STATUS_BAD;
            end else begin
               code_in   = shift_nxt;
               key_in    = key_hit ? key_idx : 3'd0;
               status_in = key_hit ? STATUS_MATCH : STATUS_NOMATCH;
            end
         end else if (active_ff) begin
            cnt_in   = cnt_nxt;
            shift_in = shift_nxt;
            bad_in   = bad_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= '{START_INTERVAL_RST, ONE_INTERVAL_RST,
                         ZERO_INTERVAL_RST, TOLERANCE_RST};
         s1_vld_ff  <= 1'b0;
         last_ff    <= '0;
         active_ff  <= 1'b0;
         cnt_ff     <= '0;
         shift_ff   <= '0;
         bad_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         s1_vld_ff  <= s1_vld_in;
         last_ff    <= last_in;
         active_ff  <= active_in;
         cnt_ff     <= cnt_in;
         shift_ff   <= shift_in;
         bad_ff     <= bad_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_time_ff <= req_tdata;
      end
      code_ff   <= code_in;
      key_ff    <= key_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'd0, key_ff, code_ff};
   assign rsp_tuser  = status_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_bad_code_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && status_ff == STATUS_BAD) |-> (code_ff == '0 && key_ff == 3'd0))
      else $error("bad-pulse result carries a non-zero code");

   a_key_only_on_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && status_ff != STATUS_MATCH) |-> (key_ff == 3'd0))
      else $error("key index set without a match");

   a_idle_count_clear: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (cnt_ff == '0 && shift_ff == '0 && !bad_ff))
      else $error("frame state left over outside a frame");

   a_count_below_frame: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNT_BITS'(FRAME_BITS))
      else $error("bit count reached the frame length without closing");

   a_done_closes_frame: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && frame_done) |=> (!active_ff && rsp_vld_ff))
      else $error("completed frame did not produce a result");

endmodule

/* design/irpd_classify.sv */
// ----------------------------------------------------------------------------
// irpd_classify
// Works out the edge-to-edge interval modulo the timer width and classes it
// against the start, one and zero gaps within the tolerance window.
// ----------------------------------------------------------------------------
module irpd_classify
   import irpd_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic [TIMER_BITS-1:0] now_time,
   input  logic [TIMER_BITS-1:0] last_time,
   input  cfg_type               cfg,
   output class_type             cls
);

   logic [TIMER_BITS-1:0] interval;
   logic [TIMER_BITS-1:0] tol_ext;

   function automatic logic near_value(input logic [TIMER_BITS-1:0] d,
                                       input logic [CSR_DATA_BITS-1:0] target,
                                       input logic [TIMER_BITS-1:0] tol);
      logic [TIMER_BITS-1:0] t;
      logic [TIMER_BITS-1:0] diff;
      t    = TIMER_BITS'(target);
      diff = (d >= t) ? d - t : t - d;
      return diff < tol;
   endfunction

   always_comb begin
      // wraps naturally at the timer width
      interval      = now_time - last_time;
      tol_ext       = TIMER_BITS'(cfg.tolerance);
      cls.start_gap = near_value(interval, cfg.start_interval, tol_ext);
      cls.bit_one   = near_value(interval, cfg.one_interval, tol_ext);
      cls.bit_zero  = near_value(interval, cfg.zero_interval, tol_ext);
   end

endmodule
